>>> hdl/hmhs_pkg.sv
// Shared types and constants for the heightmap height sampler.
package hmhs_pkg;

    localparam int MAX_VERTS_PER_ROW = 256;
    localparam int MAX_VERTS_PER_COL = 256;

    localparam logic [23:0] HEIGHT_MAX = 24'd16776960;

    // Configuration register indexes.
    localparam logic [1:0] REG_VERTS_PER_ROW = 2'd0;
    localparam logic [1:0] REG_VERTS_PER_COL = 2'd1;
    localparam logic [1:0] REG_CELL_SPACING  = 2'd2;

    // Request codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Pipeline stage numbers.
    localparam int ST_IN      = 0;
    localparam int ST_POS     = 1;
    localparam int DIVA_FIRST = 2;
    localparam int DIVA_N     = 5;
    localparam int ST_IDX     = DIVA_FIRST + DIVA_N;
    localparam int ST_ADDR    = ST_IDX + 1;
    localparam int ST_MEM     = ST_ADDR + 1;
    localparam int ST_TRI     = ST_MEM + 1;
    localparam int ST_MUL     = ST_TRI + 1;
    localparam int ST_SUM     = ST_MUL + 1;
    localparam int ST_MAG     = ST_SUM + 1;
    localparam int DIVB_FIRST = ST_MAG + 1;
    localparam int DIVB_N     = 7;
    localparam int ST_FIN     = DIVB_FIRST + DIVB_N;
    localparam int NSTAGE     = ST_FIN + 1;

    localparam int DIV_STEPS  = 4;

    typedef struct packed {
        logic        req;
        logic        wr_ok;
        logic [15:0] val;
        logic [23:0] qx;
        logic [23:0] qz;
        logic [15:0] width;
        logic [15:0] depth;
        logic        pxneg;
        logic        pzneg;
        logic [7:0]  xl;
        logic [7:0]  zl;
        logic [19:0] xdq;
        logic [19:0] zdq;
        logic [7:0]  xrem;
        logic [7:0]  zrem;
        logic        oor;
        logic [15:0] idx;
        logic [15:0] rx;
        logic [15:0] rz;
        logic [14:0] ea0;
        logic [14:0] oa0;
        logic [14:0] ea1;
        logic [14:0] oa1;
        logic        par0;
        logic        par1;
        logic [15:0] base;
        logic [16:0] d1;
        logic [16:0] d2;
        logic [15:0] m1;
        logic [15:0] m2;
        logic [33:0] p1;
        logic [33:0] p2;
        logic [35:0] n2;
        logic        neg;
        logic [27:0] bdq;
        logic [9:0]  brem;
        logic [23:0] height;
    } pipe_t;

endpackage

>>> hdl/heightmap_height_sample.sv
// Heightmap store with triangle-interpolated height queries.
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | req_type, entry_row/col/value, query_x/z
//  m_      | out       | m_valid/m_ready  | height_q8, out_of_range
//  cfg_    | in        | cfg_we           | cfg_index, cfg_wdata
//
// A word goes through 22 register stages; one word can be accepted every cycle
// while the output is not stalled.
// The cell divide takes 5 stages and the rounding divide 7 stages, 4 bits each.
// The store is two banks (even and odd address), each read twice per cycle when the memory stage moves on.
// Reset clears valid bits and sets the configuration to its defaults; the store is not cleared.
// A stall at the output closes only the bubbles in front of it.
module heightmap_height_sample
    import hmhs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_entry_row,
    input  logic [7:0]  s_entry_col,
    input  logic [15:0] s_entry_value,
    input  logic [23:0] s_query_x,
    input  logic [23:0] s_query_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_height_q8,
    output logic        m_out_of_range
);

    logic [8:0] vpr_reg;
    logic [8:0] vpc_reg;
    logic [7:0] sp_reg;
    logic [8:0] vpr_eff;
    logic [8:0] vpc_eff;
    logic [7:0] sp_eff;

    pipe_t             pipe_reg  [NSTAGE];
    pipe_t             pipe_next [NSTAGE];
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] stage_en;

    logic [15:0] even_mem [32768];
    logic [15:0] odd_mem  [32768];
    logic [15:0] rd_e0_reg;
    logic [15:0] rd_o0_reg;
    logic [15:0] rd_e1_reg;
    logic [15:0] rd_o1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vpr_reg <= 9'd129;
            vpc_reg <= 9'd129;
            sp_reg  <= 8'd10;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_VERTS_PER_ROW: vpr_reg <= cfg_wdata;
                REG_VERTS_PER_COL: vpc_reg <= cfg_wdata;
                REG_CELL_SPACING:  sp_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        vpr_eff = (vpr_reg < 9'd2) ? 9'd2 :
                  (vpr_reg > 9'(MAX_VERTS_PER_ROW)) ? 9'(MAX_VERTS_PER_ROW) : vpr_reg;
        vpc_eff = (vpc_reg < 9'd2) ? 9'd2 :
                  (vpc_reg > 9'(MAX_VERTS_PER_COL)) ? 9'(MAX_VERTS_PER_COL) : vpc_reg;
        sp_eff  = (sp_reg == 8'd0) ? 8'd1 : sp_reg;
    end

    // Each stage moves on when it is empty or the stage after it moves on.
    always_comb begin
        stage_en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_ready = stage_en[0];

    always_comb begin
        logic [16:0] wr_sum;
        logic [25:0] px;
        logic [25:0] pz;
        logic [8:0]  r9;
        logic [10:0] r11;
        logic        qb;
        logic [8:0]  vpr_m2;
        logic [8:0]  vpc_m2;
        logic [16:0] rd_sum;
        logic [16:0] p1_sum;
        logic [16:0] ev0;
        logic [16:0] ev1;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        logic [16:0] s17;
        logic [15:0] s16;
        logic [34:0] sum35;
        logic [35:0] negv;
        logic [35:0] mag;
        logic [28:0] qs;
        logic [29:0] hsum;

        for (int k = 1; k < NSTAGE; k++) begin
            pipe_next[k] = pipe_reg[k-1];
        end

        // Input stage: grid extent and write address.
        pipe_next[ST_IN]       = '0;
        pipe_next[ST_IN].req   = s_req_type;
        pipe_next[ST_IN].val   = s_entry_value;
        pipe_next[ST_IN].qx    = s_query_x;
        pipe_next[ST_IN].qz    = s_query_z;
        pipe_next[ST_IN].wr_ok = ({1'b0, s_entry_row} < vpc_eff) &&
                                 ({1'b0, s_entry_col} < vpr_eff);
        wr_sum = 17'(s_entry_row * vpr_eff) + {9'b0, s_entry_col};
        pipe_next[ST_IN].idx   = wr_sum[15:0];
        pipe_next[ST_IN].width = 16'((vpr_eff - 9'd1) * sp_eff);
        pipe_next[ST_IN].depth = 16'((vpc_eff - 9'd1) * sp_eff);

        // Center the position on the grid.
        px = {{2{pipe_reg[ST_IN].qx[23]}}, pipe_reg[ST_IN].qx}
           + {3'b0, pipe_reg[ST_IN].width, 7'b0};
        pz = {3'b0, pipe_reg[ST_IN].depth, 7'b0}
           - {{2{pipe_reg[ST_IN].qz[23]}}, pipe_reg[ST_IN].qz};
        pipe_next[ST_POS].pxneg = px[25];
        pipe_next[ST_POS].pzneg = pz[25];
        pipe_next[ST_POS].xl    = px[7:0];
        pipe_next[ST_POS].zl    = pz[7:0];
        pipe_next[ST_POS].xdq   = {3'b0, px[24:8]};
        pipe_next[ST_POS].zdq   = {3'b0, pz[24:8]};
        pipe_next[ST_POS].xrem  = '0;
        pipe_next[ST_POS].zrem  = '0;

        // Cell divide: the whole part of the position over the spacing.
        for (int k = DIVA_FIRST; k < DIVA_FIRST + DIVA_N; k++) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r9 = {pipe_next[k].xrem, pipe_next[k].xdq[19]};
                qb = (r9 >= {1'b0, sp_eff});
                if (qb) begin
                    r9 = r9 - {1'b0, sp_eff};
                end
                pipe_next[k].xrem = r9[7:0];
                pipe_next[k].xdq  = {pipe_next[k].xdq[18:0], qb};
                r9 = {pipe_next[k].zrem, pipe_next[k].zdq[19]};
                qb = (r9 >= {1'b0, sp_eff});
                if (qb) begin
                    r9 = r9 - {1'b0, sp_eff};
                end
                pipe_next[k].zrem = r9[7:0];
                pipe_next[k].zdq  = {pipe_next[k].zdq[18:0], qb};
            end
        end

        // Cell bounds and the linear index of the upper-left corner.
        vpr_m2 = vpr_eff - 9'd2;
        vpc_m2 = vpc_eff - 9'd2;
        pipe_next[ST_IDX].oor = pipe_reg[ST_IDX-1].pxneg || pipe_reg[ST_IDX-1].pzneg ||
                                (pipe_reg[ST_IDX-1].xdq > {11'b0, vpr_m2}) ||
                                (pipe_reg[ST_IDX-1].zdq > {11'b0, vpc_m2});
        pipe_next[ST_IDX].rx  = {pipe_reg[ST_IDX-1].xrem, pipe_reg[ST_IDX-1].xl};
        pipe_next[ST_IDX].rz  = {pipe_reg[ST_IDX-1].zrem, pipe_reg[ST_IDX-1].zl};
        rd_sum = 17'(pipe_reg[ST_IDX-1].zdq[7:0] * vpr_eff)
               + {9'b0, pipe_reg[ST_IDX-1].xdq[7:0]};
        if (pipe_reg[ST_IDX-1].req == REQ_QUERY) begin
            pipe_next[ST_IDX].idx = rd_sum[15:0];
        end

        // Bank addresses for the top pair and the bottom pair of corners.
        p1_sum = {1'b0, pipe_reg[ST_IDX].idx} + {8'b0, vpr_eff};
        ev0 = {1'b0, pipe_reg[ST_IDX].idx} + {16'b0, pipe_reg[ST_IDX].idx[0]};
        ev1 = {1'b0, p1_sum[15:0]} + {16'b0, p1_sum[0]};
        pipe_next[ST_ADDR].ea0  = ev0[15:1];
        pipe_next[ST_ADDR].oa0  = pipe_reg[ST_IDX].idx[15:1];
        pipe_next[ST_ADDR].ea1  = ev1[15:1];
        pipe_next[ST_ADDR].oa1  = p1_sum[15:1];
        pipe_next[ST_ADDR].par0 = pipe_reg[ST_IDX].idx[0];
        pipe_next[ST_ADDR].par1 = p1_sum[0];

        // Triangle choice and the operands of both products.
        a = pipe_reg[ST_MEM].par0 ? rd_o0_reg : rd_e0_reg;
        b = pipe_reg[ST_MEM].par0 ? rd_e0_reg : rd_o0_reg;
        c = pipe_reg[ST_MEM].par1 ? rd_o1_reg : rd_e1_reg;
        d = pipe_reg[ST_MEM].par1 ? rd_e1_reg : rd_o1_reg;
        s17 = {1'b0, sp_eff, 8'b0};
        s16 = {sp_eff, 8'b0};
        if (({1'b0, pipe_reg[ST_MEM].rx} + {1'b0, pipe_reg[ST_MEM].rz}) < s17) begin
            pipe_next[ST_TRI].base = a;
            pipe_next[ST_TRI].d1   = {1'b0, b} - {1'b0, a};
            pipe_next[ST_TRI].m1   = pipe_reg[ST_MEM].rx;
            pipe_next[ST_TRI].d2   = {1'b0, c} - {1'b0, a};
            pipe_next[ST_TRI].m2   = pipe_reg[ST_MEM].rz;
        end else begin
            pipe_next[ST_TRI].base = d;
            pipe_next[ST_TRI].d1   = {1'b0, c} - {1'b0, d};
            pipe_next[ST_TRI].m1   = s16 - pipe_reg[ST_MEM].rx;
            pipe_next[ST_TRI].d2   = {1'b0, b} - {1'b0, d};
            pipe_next[ST_TRI].m2   = s16 - pipe_reg[ST_MEM].rz;
        end

        pipe_next[ST_MUL].p1 = 34'($signed(pipe_reg[ST_TRI].d1) *
                                   $signed({1'b0, pipe_reg[ST_TRI].m1}));
        pipe_next[ST_MUL].p2 = 34'($signed(pipe_reg[ST_TRI].d2) *
                                   $signed({1'b0, pipe_reg[ST_TRI].m2}));

        // Numerator of the rounded divide: 2n + spacing.
        sum35 = {pipe_reg[ST_MUL].p1[33], pipe_reg[ST_MUL].p1}
              + {pipe_reg[ST_MUL].p2[33], pipe_reg[ST_MUL].p2};
        pipe_next[ST_SUM].n2 = {sum35, 1'b0} + {28'b0, sp_eff};

        // A negative numerator is turned into the magnitude that floors correctly.
        negv = 36'd0 - pipe_reg[ST_SUM].n2 + {27'b0, sp_eff, 1'b0} - 36'd1;
        mag  = pipe_reg[ST_SUM].n2[35] ? negv : pipe_reg[ST_SUM].n2;
        pipe_next[ST_MAG].neg  = pipe_reg[ST_SUM].n2[35];
        pipe_next[ST_MAG].bdq  = mag[27:0];
        pipe_next[ST_MAG].brem = {4'b0, mag[33:28]};

        for (int k = DIVB_FIRST; k < DIVB_FIRST + DIVB_N; k++) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                r11 = {pipe_next[k].brem, pipe_next[k].bdq[27]};
                qb  = (r11 >= {2'b0, sp_eff, 1'b0});
                if (qb) begin
                    r11 = r11 - {2'b0, sp_eff, 1'b0};
                end
                pipe_next[k].brem = r11[9:0];
                pipe_next[k].bdq  = {pipe_next[k].bdq[26:0], qb};
            end
        end

        // Final height with clamping; writes and out-of-range words give zero.
        qs = pipe_reg[ST_FIN-1].neg ? (29'd0 - {1'b0, pipe_reg[ST_FIN-1].bdq})
                                    : {1'b0, pipe_reg[ST_FIN-1].bdq};
        hsum = {6'b0, pipe_reg[ST_FIN-1].base, 8'b0} + {qs[28], qs};
        if (pipe_reg[ST_FIN-1].req == REQ_WRITE || pipe_reg[ST_FIN-1].oor || hsum[29]) begin
            pipe_next[ST_FIN].height = '0;
        end else if (hsum > {6'b0, HEIGHT_MAX}) begin
            pipe_next[ST_FIN].height = HEIGHT_MAX;
        end else begin
            pipe_next[ST_FIN].height = hsum[23:0];
        end
        pipe_next[ST_FIN].oor = (pipe_reg[ST_FIN-1].req == REQ_QUERY) &&
                                pipe_reg[ST_FIN-1].oor;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTAGE; k++) begin
            if (stage_en[k]) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // Height store: a write lands in the same stage where queries read.
    always_ff @(posedge aclk) begin
        if (stage_en[ST_MEM]) begin
            if (valid_reg[ST_ADDR] && pipe_reg[ST_ADDR].req == REQ_WRITE &&
                pipe_reg[ST_ADDR].wr_ok) begin
                if (pipe_reg[ST_ADDR].par0) begin
                    odd_mem[pipe_reg[ST_ADDR].oa0] <= pipe_reg[ST_ADDR].val;
                end else begin
                    even_mem[pipe_reg[ST_ADDR].ea0] <= pipe_reg[ST_ADDR].val;
                end
            end
            rd_e0_reg <= even_mem[pipe_reg[ST_ADDR].ea0];
            rd_o0_reg <= odd_mem[pipe_reg[ST_ADDR].oa0];
            rd_e1_reg <= even_mem[pipe_reg[ST_ADDR].ea1];
            rd_o1_reg <= odd_mem[pipe_reg[ST_ADDR].oa1];
        end
    end

    assign m_valid        = valid_reg[NSTAGE-1];
    assign m_height_q8    = pipe_reg[NSTAGE-1].height;
    assign m_out_of_range = pipe_reg[NSTAGE-1].oor;

`ifndef ASSERT_OFF
    a_ready_only_on_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the pipeline had room");

    a_oor_zero_height: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_of_range) |-> (m_height_q8 == 24'd0))
        else $error("out-of-range word carries a height");

    a_cell_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_IDX-1] |-> (pipe_reg[ST_IDX-1].xrem < sp_eff &&
                                 pipe_reg[ST_IDX-1].zrem < sp_eff))
        else $error("cell divide remainder not below spacing");

    // Only query words on the grid are checked: the remainder stays below twice the spacing.
    a_round_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_FIN-1] && pipe_reg[ST_FIN-1].req == REQ_QUERY &&
         !pipe_reg[ST_FIN-1].oor)
        |-> (pipe_reg[ST_FIN-1].brem < {1'b0, sp_eff, 1'b0}))
        else $error("rounding divide remainder not below divisor");
`endif

endmodule
